@@ hdl/cpfl_pkg.sv @@
// Package for the chunked pool free-list allocator.
// Holds operation and status codes, controller states and the
// command/status structs shared by controller and datapath.
package cpfl_pkg;

   localparam int OpWidth     = 2;
   localparam int StatusWidth = 2;
   localparam int CfgWidth    = 13;
   localparam int BytesWidth  = 20;
   localparam logic [BytesWidth-1:0] BytesMax = '1;

   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_TRIM  = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EXHAUSTED = 2'd1,
      ST_REJECTED  = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_GROW,
      S_POP,
      S_FREE,
      S_TRIM_CHUNK,
      S_TRIM_SCAN,
      S_TRIM_WALK,
      S_TRIM_NEXT,
      S_COUNT,
      S_BYTES,
      S_RESULT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;      // latch the accepted request
      logic dispatch;     // evaluate the request, set flags
      logic grow_step;    // push one slot of the new chunk
      logic grow_done;    // link the new chunk in as newest
      logic pop;          // pop the head slot
      logic free_push;    // push the freed slot
      logic trim_start;   // start the chunk walk
      logic trim_chunk;   // load the current chunk
      logic scan_step;    // check one busy bit of the chunk
      logic walk_start;   // start the free list walk
      logic walk_step;    // visit one free list entry
      logic trim_next;    // release or keep the chunk, advance
      logic count_step;   // count one chunk if it is active
      logic bytes_mul;    // form byte products
      logic result;       // load the output register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      op_type op;
      logic   head_empty;
      logic   can_grow;
      logic   free_ok;
      logic   grow_last;
      logic   chunk_none;
      logic   scan_last;
      logic   scan_busy;
      logic   release_ok;
      logic   walk_end;
      logic   count_last;
   } stat_type;

endpackage

@@ hdl/cpfl_ctrl.sv @@
// Controller state machine of the chunked pool free-list allocator.
// Sequences allocate, free and trim over the datapath; uses cpfl_pkg.
module cpfl_ctrl
   import cpfl_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_fire,
   input  logic     rsp_free,
   input  stat_type stat,
   output logic     busy,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            busy = 1'b0;
            if (req_fire) begin
               cmd.capture = 1'b1;
               state_in    = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            cmd.dispatch = 1'b1;
            priority case (stat.op)
               OP_ALLOC: begin
                  if (!stat.head_empty) begin
                     state_in = S_POP;
                  end else if (stat.can_grow) begin
                     state_in = S_GROW;
                  end else begin
                     state_in = S_COUNT;
                  end
               end
               OP_FREE: state_in = stat.free_ok ? S_FREE : S_COUNT;
               OP_TRIM: begin
                  cmd.trim_start = 1'b1;
                  state_in       = S_TRIM_CHUNK;
               end
               default: state_in = S_COUNT;
            endcase
         end
         S_GROW: begin
            cmd.grow_step = 1'b1;
            if (stat.grow_last) begin
               // Dispatch again so that the link of the new head is read
               // before the pop.
               cmd.grow_done = 1'b1;
               state_in      = S_DISPATCH;
            end
         end
         S_POP: begin
            cmd.pop  = 1'b1;
            state_in = S_COUNT;
         end
         S_FREE: begin
            cmd.free_push = 1'b1;
            state_in      = S_COUNT;
         end
         S_TRIM_CHUNK: begin
            if (stat.chunk_none) begin
               state_in = S_COUNT;
            end else begin
               cmd.trim_chunk = 1'b1;
               state_in       = S_TRIM_SCAN;
            end
         end
         S_TRIM_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_busy) begin
               cmd.trim_next = 1'b1;
               state_in      = S_TRIM_CHUNK;
            end else if (stat.scan_last) begin
               if (stat.release_ok) begin
                  cmd.walk_start = 1'b1;
                  state_in       = S_TRIM_WALK;
               end else begin
                  cmd.trim_next = 1'b1;
                  state_in      = S_TRIM_CHUNK;
               end
            end
         end
         S_TRIM_WALK: begin
            if (stat.walk_end) begin
               state_in = S_TRIM_NEXT;
            end else begin
               cmd.walk_step = 1'b1;
            end
         end
         S_TRIM_NEXT: begin
            cmd.trim_next = 1'b1;
            state_in      = S_TRIM_CHUNK;
         end
         S_COUNT: begin
            cmd.count_step = 1'b1;
            if (stat.count_last) begin
               state_in = S_BYTES;
            end
         end
         S_BYTES: begin
            cmd.bytes_mul = 1'b1;
            if (rsp_free) begin
               state_in = S_RESULT;
            end
         end
         S_RESULT: begin
            cmd.result = 1'b1;
            state_in   = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

@@ hdl/cpfl_dp.sv @@
// Datapath of the chunked pool free-list allocator: link memory, busy
// bits, chunk list, counters and output register; uses cpfl_pkg.
module cpfl_dp
   import cpfl_pkg::*;
#(
   parameter int CHUNKS          = 8,
   parameter int SLOTS_PER_CHUNK = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output stat_type               stat,
   input  logic [OpWidth-1:0]     req_op,
   input  logic [6:0]             req_slot,
   input  logic                   csr_we,
   input  logic [CfgWidth-1:0]    csr_wdata,
   input  logic                   rsp_tready,
   output logic                   rsp_valid,
   output logic [6:0]             rsp_granted_slot,
   output logic [StatusWidth-1:0] rsp_status,
   output logic [7:0]             rsp_used_slots,
   output logic [3:0]             rsp_active_chunks,
   output logic [3:0]             rsp_released_chunks,
   output logic [BytesWidth-1:0]  rsp_used_bytes,
   output logic [BytesWidth-1:0]  rsp_pool_bytes
);

   localparam int Total = CHUNKS * SLOTS_PER_CHUNK;
   localparam int SW    = (Total > 1) ? $clog2(Total) : 1;   // slot index bits
   localparam int LW    = SW + 1;                             // link incl. none
   localparam int CW    = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
   localparam int KW    = CW + 1;                             // chunk incl. none
   localparam int PW    = (SLOTS_PER_CHUNK > 1) ? $clog2(SLOTS_PER_CHUNK) : 1;
   localparam int UW    = $clog2(Total + 1);
   localparam int AW    = $clog2(CHUNKS + 1);
   localparam logic [LW-1:0] NoSlot  = LW'(Total);
   localparam logic [KW-1:0] NoChunk = KW'(CHUNKS);
   localparam logic [PW-1:0] PosLast = PW'(SLOTS_PER_CHUNK - 1);
   localparam logic [CW-1:0] ChLast  = CW'(CHUNKS - 1);

   // Link memory; at most one write and one registered read each cycle.
   logic [LW-1:0] link_mem [Total];
   logic [LW-1:0] link_rd_ff;
   logic          link_we;
   logic [SW-1:0] link_wa, link_ra;
   logic [LW-1:0] link_wd;

   logic [Total-1:0]  busy_ff, busy_in;
   logic [CHUNKS-1:0] active_ff, active_in;
   logic [KW-1:0]     older_ff [CHUNKS];
   logic [KW-1:0]     newest_ff, newest_in;
   logic [LW-1:0]     head_ff, head_in;
   logic [UW-1:0]     used_ff, used_in;
   logic [CfgWidth-1:0] osize_ff;
   logic [OpWidth-1:0]  op_ff;
   logic [6:0]          slot_ff;
   logic [StatusWidth-1:0] status_ff, status_in;
   logic [6:0]          grant_ff, grant_in;
   logic [3:0]          released_ff, released_in;
   logic [CW-1:0]       grow_ch_ff, grow_ch_in;
   logic [PW-1:0]       pos_ff, pos_in;
   logic [KW-1:0]       cur_ch_ff, cur_ch_in, prev_ch_ff, prev_ch_in, nxt_ch_ff, nxt_ch_in;
   logic [LW-1:0]       prev_sl_ff, prev_sl_in, cur_sl_ff, cur_sl_in;
   logic                walk_rd_ff, walk_rd_in;
   logic [CW-1:0]       cnt_idx_ff, cnt_idx_in;
   logic [AW-1:0]       act_cnt_ff, act_cnt_in;
   logic [UW+CfgWidth-1:0] used_prod_ff;
   logic [AW+CfgWidth-1:0] act_prod_ff;
   logic                rsp_valid_ff;
   logic [6:0]          o_grant_ff;
   logic [StatusWidth-1:0] o_status_ff;
   logic [7:0]          o_used_ff;
   logic [3:0]          o_act_ff, o_rel_ff;
   logic [BytesWidth-1:0] o_ub_ff, o_pb_ff;

   logic [CW-1:0] low_inactive;
   logic          any_inactive;
   logic [SW-1:0] grow_slot, scan_slot;
   logic          free_active;
   logic [LW-1:0] ch_base;
   logic          cur_in_chunk;
   logic          older_we;
   logic [CW-1:0] older_wa;
   logic [KW-1:0] older_wd;

   always_comb begin
      low_inactive = '0;
      any_inactive = 1'b0;
      for (int i = CHUNKS - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            low_inactive = CW'(i);
            any_inactive = 1'b1;
         end
      end
   end

   // The freed slot must lie inside an active chunk.
   always_comb begin
      free_active = 1'b0;
      for (int i = 0; i < CHUNKS; i++) begin
         if (LW'(slot_ff) >= LW'(i * SLOTS_PER_CHUNK) &&
             LW'(slot_ff) < LW'((i + 1) * SLOTS_PER_CHUNK) && active_ff[i]) begin
            free_active = 1'b1;
         end
      end
   end

   assign grow_slot    = SW'(grow_ch_ff) * SW'(SLOTS_PER_CHUNK) + SW'(pos_ff);
   assign scan_slot    = SW'(cur_ch_ff[CW-1:0]) * SW'(SLOTS_PER_CHUNK) + SW'(pos_ff);
   assign ch_base      = LW'(cur_ch_ff[CW-1:0]) * LW'(SLOTS_PER_CHUNK);
   assign cur_in_chunk = (cur_sl_ff >= ch_base) &&
                         (cur_sl_ff < ch_base + LW'(SLOTS_PER_CHUNK));

   always_comb begin
      stat            = '0;
      stat.op         = op_type'(op_ff);
      stat.head_empty = (head_ff == NoSlot);
      stat.can_grow   = any_inactive;
      stat.free_ok    = free_active && busy_ff[SW'(slot_ff)];
      stat.grow_last  = (pos_ff == PosLast);
      stat.chunk_none = (cur_ch_ff == NoChunk);
      stat.scan_last  = (pos_ff == PosLast);
      stat.scan_busy  = busy_ff[scan_slot];
      stat.release_ok = (prev_ch_ff != NoChunk) || (nxt_ch_ff != NoChunk);
      stat.walk_end   = walk_rd_ff && (cur_sl_ff == NoSlot);
      stat.count_last = (cnt_idx_ff == ChLast);
   end

   // Link memory port control.
   always_comb begin
      link_we = 1'b0;
      link_wa = '0;
      link_wd = head_ff;
      link_ra = head_ff[SW-1:0];
      if (cmd.grow_step) begin
         link_we = 1'b1;
         link_wa = grow_slot;
      end else if (cmd.free_push) begin
         link_we = 1'b1;
         link_wa = SW'(slot_ff);
      end else if (cmd.walk_step && walk_rd_ff && cur_in_chunk
                   && prev_sl_ff != NoSlot) begin
         link_we = 1'b1;
         link_wa = prev_sl_ff[SW-1:0];
         link_wd = link_rd_ff;
      end
      if (cmd.walk_start) begin
         link_ra = head_ff[SW-1:0];
      end else if (cmd.walk_step) begin
         link_ra = walk_rd_ff ? link_rd_ff[SW-1:0] : cur_sl_ff[SW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_wa] <= link_wd;
      end
      link_rd_ff <= link_mem[link_ra];
   end

   always_comb begin
      older_we = 1'b0;
      older_wa = grow_ch_ff;
      older_wd = newest_ff;
      if (cmd.grow_done) begin
         older_we = 1'b1;
      end else if (cmd.trim_next && walk_rd_ff && prev_ch_ff != NoChunk) begin
         older_we = 1'b1;
         older_wa = prev_ch_ff[CW-1:0];
         older_wd = nxt_ch_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (older_we) begin
         older_ff[older_wa] <= older_wd;
      end
   end

   always_comb begin
      busy_in     = busy_ff;
      active_in   = active_ff;
      newest_in   = newest_ff;
      head_in     = head_ff;
      used_in     = used_ff;
      status_in   = status_ff;
      grant_in    = grant_ff;
      released_in = released_ff;
      grow_ch_in  = grow_ch_ff;
      pos_in      = pos_ff;
      cur_ch_in   = cur_ch_ff;
      prev_ch_in  = prev_ch_ff;
      nxt_ch_in   = nxt_ch_ff;
      prev_sl_in  = prev_sl_ff;
      cur_sl_in   = cur_sl_ff;
      walk_rd_in  = walk_rd_ff;
      cnt_idx_in  = cnt_idx_ff;
      act_cnt_in  = act_cnt_ff;

      if (cmd.dispatch) begin
         status_in   = ST_OK;
         grant_in    = '0;
         released_in = '0;
         grow_ch_in  = low_inactive;
         pos_in      = '0;
         cnt_idx_in  = '0;
         act_cnt_in  = '0;
         if (op_ff == OP_ALLOC && head_ff == NoSlot && !any_inactive) begin
            status_in = ST_EXHAUSTED;
         end
         if (op_ff == OP_FREE && !stat.free_ok) begin
            status_in = ST_REJECTED;
         end
      end
      if (cmd.grow_step) begin
         busy_in[grow_slot] = 1'b0;
         head_in            = LW'(grow_slot);
         pos_in             = pos_ff + 1'b1;
      end
      if (cmd.grow_done) begin
         newest_in              = KW'(grow_ch_ff);
         active_in[grow_ch_ff]  = 1'b1;
      end
      if (cmd.pop) begin
         busy_in[head_ff[SW-1:0]] = 1'b1;
         head_in  = link_rd_ff;
         used_in  = used_ff + 1'b1;
         grant_in = 7'(head_ff);
      end
      if (cmd.free_push) begin
         busy_in[SW'(slot_ff)] = 1'b0;
         head_in = LW'(slot_ff);
         used_in = used_ff - 1'b1;
      end
      if (cmd.trim_start) begin
         cur_ch_in  = newest_ff;
         prev_ch_in = NoChunk;
      end
      if (cmd.trim_chunk) begin
         pos_in     = '0;
         nxt_ch_in  = older_ff[cur_ch_ff[CW-1:0]];
         walk_rd_in = 1'b0;
      end
      if (cmd.scan_step) begin
         pos_in = pos_ff + 1'b1;
      end
      if (cmd.walk_start) begin
         prev_sl_in = NoSlot;
         cur_sl_in  = head_ff;
         walk_rd_in = 1'b0;
      end
      if (cmd.walk_step) begin
         if (!walk_rd_ff) begin
            // First cycle: the read of the head entry is in flight.
            walk_rd_in = (cur_sl_ff != NoSlot);
            if (cur_sl_ff == NoSlot) begin
               walk_rd_in = 1'b1;
            end
         end else begin
            if (cur_in_chunk) begin
               if (prev_sl_ff == NoSlot) begin
                  head_in = link_rd_ff;
               end
            end else begin
               prev_sl_in = cur_sl_ff;
            end
            cur_sl_in = link_rd_ff;
         end
      end
      if (cmd.trim_next) begin
         // walk_rd_ff marks a chunk that went through the unlink walk.
         if (walk_rd_ff) begin
            active_in[cur_ch_ff[CW-1:0]] = 1'b0;
            released_in = released_ff + 1'b1;
            if (prev_ch_ff == NoChunk) begin
               newest_in = nxt_ch_ff;
            end
         end else begin
            prev_ch_in = cur_ch_ff;
         end
         cur_ch_in  = nxt_ch_ff;
         walk_rd_in = 1'b0;
      end
      if (cmd.count_step) begin
         act_cnt_in = act_cnt_ff + AW'(active_ff[cnt_idx_ff]);
         cnt_idx_in = cnt_idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= '0;
         active_ff    <= '0;
         newest_ff    <= NoChunk;
         head_ff      <= NoSlot;
         used_ff      <= '0;
         osize_ff     <= CfgWidth'(16);
         rsp_valid_ff <= 1'b0;
         walk_rd_ff   <= 1'b0;
      end else begin
         busy_ff    <= busy_in;
         active_ff  <= active_in;
         newest_ff  <= newest_in;
         head_ff    <= head_in;
         used_ff    <= used_in;
         walk_rd_ff <= walk_rd_in;
         if (csr_we) begin
            osize_ff <= csr_wdata;
         end
         if (cmd.result) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      status_ff   <= status_in;
      grant_ff    <= grant_in;
      released_ff <= released_in;
      grow_ch_ff  <= grow_ch_in;
      pos_ff      <= pos_in;
      cur_ch_ff   <= cur_ch_in;
      prev_ch_ff  <= prev_ch_in;
      nxt_ch_ff   <= nxt_ch_in;
      prev_sl_ff  <= prev_sl_in;
      cur_sl_ff   <= cur_sl_in;
      cnt_idx_ff  <= cnt_idx_in;
      act_cnt_ff  <= act_cnt_in;
      if (cmd.capture) begin
         op_ff   <= req_op;
         slot_ff <= req_slot;
      end
      if (cmd.bytes_mul) begin
         used_prod_ff <= (UW+CfgWidth)'(used_ff) * (UW+CfgWidth)'(osize_ff);
         act_prod_ff  <= (AW+CfgWidth)'(act_cnt_ff) * (AW+CfgWidth)'(osize_ff);
      end
   end

   // Pool bytes: active chunks times object size, then times the chunk size.
   logic [AW+CfgWidth+11:0] pool_full;
   assign pool_full = (AW+CfgWidth+12)'(act_prod_ff) * (AW+CfgWidth+12)'(SLOTS_PER_CHUNK);

   always_ff @(posedge clock) begin
      if (cmd.result) begin
         o_grant_ff  <= grant_ff;
         o_status_ff <= status_ff;
         o_used_ff   <= 8'(used_ff);
         o_act_ff    <= 4'(act_cnt_ff);
         o_rel_ff    <= released_ff;
         o_ub_ff     <= ((UW+CfgWidth+1)'(used_prod_ff) > (UW+CfgWidth+1)'(BytesMax))
                        ? BytesMax : BytesWidth'(used_prod_ff);
         o_pb_ff     <= ((AW+CfgWidth+13)'(pool_full) > (AW+CfgWidth+13)'(BytesMax))
                        ? BytesMax : BytesWidth'(pool_full);
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_granted_slot    = o_grant_ff;
   assign rsp_status          = o_status_ff;
   assign rsp_used_slots      = o_used_ff;
   assign rsp_active_chunks   = o_act_ff;
   assign rsp_released_chunks = o_rel_ff;
   assign rsp_used_bytes      = o_ub_ff;
   assign rsp_pool_bytes      = o_pb_ff;

endmodule

@@ hdl/chunked_pool_free_list_allocator.sv @@
// Chunked pool free-list allocator, top level; joins cpfl_ctrl and cpfl_dp.
// Depends on cpfl_pkg.
//
// One request (allocate, free, trim) is handled at a time and yields one
// response transaction. Every request ends with a walk that counts active
// chunks, then the byte products, which wait until the response register
// is free, then the output register. An allocate that opens a chunk first
// pushes its slots and dispatches again to read the new head. Trim loads
// each visited chunk and scans its busy bits up to the first busy one;
// for a released chunk it then walks the free list, unlinking the chunk's
// entries through the link memory.
module chunked_pool_free_list_allocator
   import cpfl_pkg::*;
#(
   parameter int CHUNKS          = 8,
   parameter int SLOTS_PER_CHUNK = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // op[1:0], slot[8:2]
   input  logic        csr_we,
   input  logic [12:0] csr_wdata,   // object_size
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata    // granted_slot, status, used_slots,
                                    // active_chunks, released_chunks,
                                    // used_bytes, pool_bytes
);

   cmd_type  cmd;
   stat_type stat;
   logic     busy;
   logic     req_fire;
   logic [6:0]  g;
   logic [1:0]  st;
   logic [7:0]  us;
   logic [3:0]  ac, rc;
   logic [19:0] ub, pb;

   assign req_tready = !busy;
   assign req_fire   = req_tvalid && !busy;

   cpfl_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .rsp_free (!rsp_tvalid || rsp_tready),
      .stat     (stat),
      .busy     (busy),
      .cmd      (cmd)
   );

   cpfl_dp #(
      .CHUNKS          (CHUNKS),
      .SLOTS_PER_CHUNK (SLOTS_PER_CHUNK)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_op              (req_tdata[1:0]),
      .req_slot            (req_tdata[8:2]),
      .csr_we              (csr_we),
      .csr_wdata           (csr_wdata),
      .rsp_tready          (rsp_tready),
      .rsp_valid           (rsp_tvalid),
      .rsp_granted_slot    (g),
      .rsp_status          (st),
      .rsp_used_slots      (us),
      .rsp_active_chunks   (ac),
      .rsp_released_chunks (rc),
      .rsp_used_bytes      (ub),
      .rsp_pool_bytes      (pb)
   );

   assign rsp_tdata = {7'd0, pb, ub, rc, ac, us, st, g};

endmodule
